### rtl/cpscan_pkg.sv
// Shared types, constants and segment tables for the charlieplexed three-digit scan unit.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package cpscan_pkg;

    localparam int VALUE_W = 8;
    localparam int SEG_W   = 16;
    localparam int PIN_W   = 5;
    localparam int PHASE_W = 3;
    localparam int DIGIT_W = 4;
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 16;

    localparam logic [VALUE_W-1:0] SHOWN_MAX = 8'd199;

    // Scan phase codes: idle, then the common pin index plus one
    localparam logic [PHASE_W-1:0] PHASE_IDLE = 3'd0;
    localparam logic [PHASE_W-1:0] PHASE_1    = 3'd1;
    localparam logic [PHASE_W-1:0] PHASE_2    = 3'd2;
    localparam logic [PHASE_W-1:0] PHASE_3    = 3'd3;
    localparam logic [PHASE_W-1:0] PHASE_4    = 3'd4;

    typedef struct packed {
        logic [PHASE_W-1:0] scan_phase;
        logic [PIN_W-1:0]   pin_high_mask;
        logic [PIN_W-1:0]   pin_output_mask;
    } pin_result_t;

    function automatic logic [SEG_W-1:0] units_seg(input logic [DIGIT_W-1:0] d);
        logic [SEG_W-1:0] s;
        begin
            unique case (d)
                4'd0:    s = 16'hE888;
                4'd1:    s = 16'h8080;
                4'd2:    s = 16'hD808;
                4'd3:    s = 16'hD880;
                4'd4:    s = 16'hB080;
                4'd5:    s = 16'h7880;
                4'd6:    s = 16'h7888;
                4'd7:    s = 16'h8880;
                4'd8:    s = 16'hF888;
                4'd9:    s = 16'hF880;
                default: s = '0;
            endcase
            return s;
        end
    endfunction

    function automatic logic [SEG_W-1:0] tens_seg(input logic [DIGIT_W-1:0] d);
        logic [SEG_W-1:0] s;
        begin
            unique case (d)
                4'd0:    s = 16'h0770;
                4'd1:    s = 16'h0420;
                4'd2:    s = 16'h0741;
                4'd3:    s = 16'h0661;
                4'd4:    s = 16'h0431;
                4'd5:    s = 16'h0271;
                4'd6:    s = 16'h0371;
                4'd7:    s = 16'h0460;
                4'd8:    s = 16'h0771;
                4'd9:    s = 16'h0671;
                default: s = '0;
            endcase
            return s;
        end
    endfunction

    function automatic logic [SEG_W-1:0] hundreds_seg(input logic d);
        return d ? 16'h0006 : 16'h0000;
    endfunction

endpackage

`default_nettype wire

### rtl/charlieplex_three_digit_scan_unit.sv
// Top level of the charlieplexed three-digit scan unit: input register, phase counter,
// result register. Depends on cpscan_pkg, cpscan_digit_decode and cpscan_pin_map.
//
// Channel  Dir  Handshake        Payload
// s_axis   in   s_tvalid/tready  s_tdata[7:0]   shown_value
// m_axis   out  m_tvalid/tready  m_tdata[15:0]  output mask, high mask, scan phase
//
// One item per cycle sustained while m_tready is high; an item passes the input register, then the result register.
// The digit split, table lookup and pin mapping sit between those two registers.
// Reset clears both valid flags and sets the phase counter to idle.
// A stall on m_tready holds the result; the input register keeps taking items
// until it is full, then s_tready drops.
`timescale 1ns / 1ps
`default_nettype none

module charlieplex_three_digit_scan_unit
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [cpscan_pkg::S_TDATA_W-1:0]   s_tdata,  // [7:0] shown_value
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic      [cpscan_pkg::M_TDATA_W-1:0]   m_tdata   // [4:0] pin_output_mask,
                                                              // [9:5] pin_high_mask,
                                                              // [12:10] scan_phase, rest 0
);

    logic                                in_valid_reg;
    logic [cpscan_pkg::VALUE_W-1:0]      in_value_reg;
    logic                                out_valid_reg;
    cpscan_pkg::pin_result_t             out_result_reg;
    logic [cpscan_pkg::PHASE_W-1:0]      phase_reg;
    logic [cpscan_pkg::PHASE_W-1:0]      phase_next;

    logic                                out_free;
    logic                                advance;
    logic [cpscan_pkg::SEG_W-1:0]        seg_word;
    cpscan_pkg::pin_result_t             result;

    cpscan_digit_decode u_decode
    (
        .shown_value (in_value_reg),
        .seg_word    (seg_word)
    );

    cpscan_pin_map u_pin_map
    (
        .phase    (phase_reg),
        .seg_word (seg_word),
        .result   (result)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_comb
    begin
        unique case (phase_reg)
            cpscan_pkg::PHASE_1: phase_next = cpscan_pkg::PHASE_2;
            cpscan_pkg::PHASE_2: phase_next = cpscan_pkg::PHASE_3;
            cpscan_pkg::PHASE_3: phase_next = cpscan_pkg::PHASE_4;
            default:             phase_next = cpscan_pkg::PHASE_1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= cpscan_pkg::PHASE_IDLE;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (out_free)
                out_valid_reg <= in_valid_reg;
            // step the scan only when an item moves into the result register
            if (advance)
                phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            in_value_reg <= s_tdata;
        if (advance)
            out_result_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_result_reg.scan_phase, out_result_reg.pin_high_mask,
                       out_result_reg.pin_output_mask};

endmodule

`default_nettype wire

### rtl/cpscan_digit_decode.sv
// Saturates the shown value, splits it into decimal digits and ORs the segment words.
// Depends on cpscan_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cpscan_digit_decode
(
    input  wire logic [cpscan_pkg::VALUE_W-1:0] shown_value,
    output logic      [cpscan_pkg::SEG_W-1:0]   seg_word
);

    logic [7:0]  sat_value;
    logic        hundreds;
    logic [6:0]  rem_value;
    logic [14:0] tens_prod;
    logic [3:0]  tens;
    logic [6:0]  tens_times10;
    logic [6:0]  units_full;
    logic [3:0]  units;

    always_comb
    begin
        sat_value = (shown_value > cpscan_pkg::SHOWN_MAX) ? cpscan_pkg::SHOWN_MAX : shown_value;
        hundreds  = (sat_value >= 8'd100);
        rem_value = hundreds ? 7'(sat_value - 8'd100) : sat_value[6:0];
        // divide by ten: exact for values below 100 via multiply by 205, shift by 11
        tens_prod    = 15'(rem_value) * 15'd205;
        tens         = tens_prod[14:11];
        tens_times10 = {tens[3:0], 3'b000} - 7'({tens, 1'b0}) + 7'({tens, 2'b00});
        units_full   = rem_value - tens_times10;
        units        = units_full[3:0];
        seg_word = cpscan_pkg::units_seg(units) | cpscan_pkg::tens_seg(tens)
                 | cpscan_pkg::hundreds_seg(hundreds);
    end

endmodule

`default_nettype wire

### rtl/cpscan_pin_map.sv
// Maps the current scan phase and the ORed segment word onto the five charlieplexed pins.
// Depends on cpscan_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cpscan_pin_map
(
    input  wire logic [cpscan_pkg::PHASE_W-1:0] phase,
    input  wire logic [cpscan_pkg::SEG_W-1:0]   seg_word,
    output cpscan_pkg::pin_result_t             result
);

    logic       active;
    logic [2:0] common;
    logic [3:0] nib;
    logic [cpscan_pkg::PIN_W-1:0] high;

    always_comb
    begin
        active = 1'b1;
        common = 3'd0;
        nib    = 4'd0;
        high   = '0;
        // slice bit 3 drives the lowest non-common pin, bit 0 the highest
        unique case (phase)
            cpscan_pkg::PHASE_1:
            begin
                common = 3'd0;
                nib    = seg_word[15:12];
                high   = {nib[0], nib[1], nib[2], nib[3], 1'b0};
            end
            cpscan_pkg::PHASE_2:
            begin
                common = 3'd1;
                nib    = seg_word[11:8];
                high   = {nib[0], nib[1], nib[2], 1'b0, nib[3]};
            end
            cpscan_pkg::PHASE_3:
            begin
                common = 3'd2;
                nib    = seg_word[7:4];
                high   = {nib[0], nib[1], 1'b0, nib[2], nib[3]};
            end
            cpscan_pkg::PHASE_4:
            begin
                common = 3'd3;
                nib    = seg_word[3:0];
                high   = {nib[0], 1'b0, nib[1], nib[2], nib[3]};
            end
            default:
            begin
                active = 1'b0;
            end
        endcase

        if (active)
        begin
            result.pin_high_mask   = high;
            result.pin_output_mask = high | (5'b00001 << common);
            result.scan_phase      = phase;
        end
        else
        begin
            result.pin_high_mask   = '0;
            result.pin_output_mask = '0;
            result.scan_phase      = cpscan_pkg::PHASE_IDLE;
        end
    end

endmodule

`default_nettype wire
